// File: sv/assert_macros.svh
// Assertion macros for the frame replay buffer RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/lpfrb_pkg.sv
// Shared types and constants of the frame replay buffer.
// No dependencies.
`default_nettype none

package lpfrb_pkg;

    localparam int BUFFER_BYTES_DEF = 65536;
    localparam int LIMIT_W          = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_ADDR_W       = 3;
    localparam logic REG_BUFFER_LIMIT = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_REWIND = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;

    localparam logic [2:0] KIND_WR_START = 3'd0;
    localparam logic [2:0] KIND_WR_BYTE  = 3'd1;
    localparam logic [2:0] KIND_REWIND   = 3'd2;
    localparam logic [2:0] KIND_CLEAR    = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] len;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// File: sv/lpfrb_front.sv
// Front end: classifies incoming commands and queues them for the back end.
// Depends on lpfrb_pkg.
`default_nettype none

module lpfrb_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [1:0]            i_cmd,
    input  wire logic                  i_first,
    input  wire logic [7:0]            i_len,
    input  wire logic [7:0]            i_data,
    input  wire logic                  i_pop,
    output lpfrb_pkg::t_item           o_head,
    output lpfrb_pkg::t_q_status       o_stat
);

    lpfrb_pkg::t_item                r_q [lpfrb_pkg::QUEUE_DEPTH];
    logic [lpfrb_pkg::QPTR_W-1:0]    r_wp, n_wp;
    logic [lpfrb_pkg::QPTR_W-1:0]    r_rp, n_rp;
    logic [lpfrb_pkg::QPTR_W:0]      r_count, n_count;
    lpfrb_pkg::t_item                w_item;
    logic                            w_push;
    logic                            w_pop;
    logic                            w_full;

    assign w_full = (r_count == (lpfrb_pkg::QPTR_W + 1)'(lpfrb_pkg::QUEUE_DEPTH));
    assign w_push = i_push && !w_full;
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        w_item.len  = i_len;
        w_item.data = i_data;
        unique case (i_cmd)
            lpfrb_pkg::CMD_WRITE: begin
                w_item.kind = i_first ? lpfrb_pkg::KIND_WR_START : lpfrb_pkg::KIND_WR_BYTE;
            end
            lpfrb_pkg::CMD_REWIND: w_item.kind = lpfrb_pkg::KIND_REWIND;
            lpfrb_pkg::CMD_CLEAR:  w_item.kind = lpfrb_pkg::KIND_CLEAR;
            default:               w_item.kind = lpfrb_pkg::KIND_READ;
        endcase
    end

    always_comb begin
        n_wp    = w_push ? r_wp + 1'b1 : r_wp;
        n_rp    = w_pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    assign o_head       = r_q[r_rp];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = w_full;

endmodule

`default_nettype wire

// File: sv/lpfrb_back.sv
// Back end: executes queued commands against the frame store memory.
// Depends on lpfrb_pkg; holds the single-port byte store.
`default_nettype none

module lpfrb_back #(
    parameter int BUFFER_BYTES = lpfrb_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lpfrb_pkg::LIMIT_W-1:0] i_limit,
    input  wire lpfrb_pkg::t_item              i_head,
    input  wire lpfrb_pkg::t_q_status          i_qstat,
    output logic                               o_pop,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [7:0]                         o_data_out,
    output logic [7:0]                         o_len_out,
    output logic                               o_first,
    output logic                               o_last
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = (CW > lpfrb_pkg::LIMIT_W) ? CW : lpfrb_pkg::LIMIT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WR2   = 2'd1;
    localparam logic [1:0] ST_RDLEN = 2'd2;
    localparam logic [1:0] ST_RDDAT = 2'd3;

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_mem_rdata;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_pp, n_pp;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [7:0]    r_rem, n_rem;
    logic          r_drop, n_drop;
    logic [7:0]    r_off, n_off;
    logic [7:0]    r_plen, n_plen;

    logic          r_done, n_done;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_dout, n_dout;
    logic [7:0]    r_lout, n_lout;
    logic          r_first, n_first;
    logic          r_last, n_last;

    logic          w_we, w_re;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata;

    logic [LW-1:0] w_lim_cfg, w_lim_buf, w_lim, w_used_ext, w_room, w_need;
    logic          w_reject;
    logic [7:0]    w_fin_len;
    logic [CW:0]   w_pp_fin;
    logic          w_fin_empty;
    logic [CW:0]   w_rd_data_addr;
    logic [CW:0]   w_used_p1, w_used_p2;
    logic [8:0]    w_off_p1;
    logic [7:0]    w_rem_dec;

    assign w_lim_cfg  = LW'(i_limit);
    assign w_lim_buf  = LW'(BUFFER_BYTES);
    assign w_lim      = (w_lim_cfg < w_lim_buf) ? w_lim_cfg : w_lim_buf;
    assign w_used_ext = LW'(r_used);
    assign w_room     = (w_lim > w_used_ext) ? (w_lim - w_used_ext) : '0;
    assign w_need     = LW'(i_head.len) + LW'(2);
    assign w_reject   = (w_room < w_need);

    assign w_fin_len      = (r_state == ST_RDLEN) ? 8'd0 : r_plen;
    assign w_pp_fin       = {1'b0, r_pp} + (CW + 1)'(w_fin_len) + (CW + 1)'(1);
    assign w_fin_empty    = (w_pp_fin >= {1'b0, r_used});
    assign w_rd_data_addr = {1'b0, r_pp} + (CW + 1)'(r_off) + (CW + 1)'(1);
    assign w_used_p1      = {1'b0, r_used} + (CW + 1)'(1);
    assign w_used_p2      = {1'b0, r_used} + (CW + 1)'(2);
    assign w_off_p1       = {1'b0, r_off} + 9'd1;
    assign w_rem_dec      = (r_rem != 8'd0) ? r_rem - 8'd1 : 8'd0;

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_pp     = r_pp;
        n_cursor = r_cursor;
        n_rem    = r_rem;
        n_drop   = r_drop;
        n_off    = r_off;
        n_plen   = r_plen;
        n_done   = 1'b0;
        n_status = lpfrb_pkg::STATUS_OK;
        n_dout   = 8'd0;
        n_lout   = 8'd0;
        n_first  = 1'b0;
        n_last   = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_addr   = r_used[AW-1:0];
        w_wdata  = i_head.len;
        o_pop    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_qstat.valid) begin
                    case (i_head.kind)
                        lpfrb_pkg::KIND_WR_START: begin
                            n_rem  = 8'd0;
                            n_drop = 1'b0;
                            if (w_reject) begin
                                n_done   = 1'b1;
                                n_status = lpfrb_pkg::STATUS_REJECT;
                                o_pop    = 1'b1;
                                if (i_head.len > 8'd1) begin
                                    n_rem  = i_head.len - 8'd1;
                                    n_drop = 1'b1;
                                end
                            end else begin
                                w_we    = 1'b1;
                                w_addr  = r_used[AW-1:0];
                                w_wdata = i_head.len;
                                if (i_head.len == 8'd0) begin
                                    n_cursor = w_used_p1[CW-1:0];
                                    n_used   = w_used_p1[CW-1:0];
                                    n_done   = 1'b1;
                                    o_pop    = 1'b1;
                                end else begin
                                    n_state = ST_WR2;
                                end
                            end
                        end
                        lpfrb_pkg::KIND_WR_BYTE: begin
                            n_done = 1'b1;
                            o_pop  = 1'b1;
                            if (r_drop) begin
                                n_status = lpfrb_pkg::STATUS_REJECT;
                                n_rem    = w_rem_dec;
                                if (w_rem_dec == 8'd0) begin
                                    n_drop = 1'b0;
                                end
                            end else if (r_rem != 8'd0) begin
                                w_we     = 1'b1;
                                w_addr   = r_cursor[AW-1:0];
                                w_wdata  = i_head.data;
                                n_cursor = r_cursor + CW'(1);
                                n_rem    = r_rem - 8'd1;
                                if (r_rem == 8'd1) begin
                                    n_used = r_cursor + CW'(1);
                                end
                            end else begin
                                n_status = lpfrb_pkg::STATUS_REJECT;
                            end
                        end
                        lpfrb_pkg::KIND_REWIND: begin
                            n_done = 1'b1;
                            o_pop  = 1'b1;
                            n_pp   = '0;
                            n_off  = 8'd0;
                        end
                        lpfrb_pkg::KIND_CLEAR: begin
                            n_done = 1'b1;
                            o_pop  = 1'b1;
                            n_used = '0;
                            n_pp   = '0;
                            n_off  = 8'd0;
                            n_plen = 8'd0;
                            n_rem  = 8'd0;
                            n_drop = 1'b0;
                        end
                        default: begin
                            if (r_used == '0) begin
                                n_done   = 1'b1;
                                n_status = lpfrb_pkg::STATUS_EMPTY;
                                o_pop    = 1'b1;
                            end else if (r_off == 8'd0) begin
                                w_re    = 1'b1;
                                w_addr  = r_pp[AW-1:0];
                                n_state = ST_RDLEN;
                            end else begin
                                w_re    = 1'b1;
                                w_addr  = w_rd_data_addr[AW-1:0];
                                n_state = ST_RDDAT;
                            end
                        end
                    endcase
                end
            end
            ST_WR2: begin
                w_we     = 1'b1;
                w_addr   = w_used_p1[AW-1:0];
                w_wdata  = i_head.data;
                n_cursor = w_used_p2[CW-1:0];
                n_rem    = i_head.len - 8'd1;
                if (i_head.len == 8'd1) begin
                    n_used = w_used_p2[CW-1:0];
                end
                n_done  = 1'b1;
                o_pop   = 1'b1;
                n_state = ST_IDLE;
            end
            ST_RDLEN: begin
                n_plen = r_mem_rdata;
                if (r_mem_rdata == 8'd0) begin
                    n_done  = 1'b1;
                    n_first = 1'b1;
                    n_last  = 1'b1;
                    o_pop   = 1'b1;
                    n_off   = 8'd0;
                    n_pp    = w_fin_empty ? '0 : w_pp_fin[CW-1:0];
                    if (w_fin_empty) begin
                        n_used = '0;
                    end
                    n_state = ST_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_addr  = w_rd_data_addr[AW-1:0];
                    n_state = ST_RDDAT;
                end
            end
            default: begin
                n_done  = 1'b1;
                o_pop   = 1'b1;
                n_dout  = r_mem_rdata;
                n_lout  = r_plen;
                n_first = (r_off == 8'd0);
                n_off   = w_off_p1[7:0];
                if (w_off_p1 >= {1'b0, r_plen}) begin
                    n_last = 1'b1;
                    n_off  = 8'd0;
                    n_pp   = w_fin_empty ? '0 : w_pp_fin[CW-1:0];
                    if (w_fin_empty) begin
                        n_used = '0;
                    end
                end
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (w_re) begin
            r_mem_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_pp     <= '0;
            r_cursor <= '0;
            r_rem    <= 8'd0;
            r_drop   <= 1'b0;
            r_off    <= 8'd0;
            r_plen   <= 8'd0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_pp     <= n_pp;
            r_cursor <= n_cursor;
            r_rem    <= n_rem;
            r_drop   <= n_drop;
            r_off    <= n_off;
            r_plen   <= n_plen;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_dout   <= n_dout;
        r_lout   <= n_lout;
        r_first  <= n_first;
        r_last   <= n_last;
    end

    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_data_out = r_dout;
    assign o_len_out  = r_lout;
    assign o_first    = r_first;
    assign o_last     = r_last;

endmodule

`default_nettype wire

// File: sv/length_prefixed_frame_replay_buffer.sv
// Frame replay buffer top: APB register, command queue front end, store back end.
// Result strobe is registered; a frame start with data also passes ST_WR2, and a read of a
// stored frame a length fetch (at a frame start), then a data fetch; queue wait comes on top.
// Throughput: one command per cycle except a frame start with data (extra ST_WR2 state) or a read
// of a stored frame (extra fetch states); a 4-entry queue absorbs bursts, results never stall.
// Reset: synchronous active low; store contents stay undefined, limit = 65536.
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_frame_replay_buffer #(
    parameter int BUFFER_BYTES = lpfrb_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       i_cmd,
    input  wire logic                             i_first_of_frame,
    input  wire logic [7:0]                       i_frame_length,
    input  wire logic [7:0]                       i_data_byte,
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [7:0]                            o_data_out,
    output logic [7:0]                            o_frame_length_out,
    output logic                                  o_frame_first,
    output logic                                  o_frame_last,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lpfrb_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [lpfrb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lpfrb_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    logic [lpfrb_pkg::LIMIT_W-1:0] r_buffer_limit;
    logic                          w_cfg_wr;
    lpfrb_pkg::t_item              w_head;
    lpfrb_pkg::t_q_status          w_qstat;
    logic                          w_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == lpfrb_pkg::REG_BUFFER_LIMIT);
    assign prdata   = (paddr[2] == lpfrb_pkg::REG_BUFFER_LIMIT)
                    ? {{(lpfrb_pkg::CFG_DATA_W - lpfrb_pkg::LIMIT_W){1'b0}}, r_buffer_limit}
                    : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_limit <= lpfrb_pkg::LIMIT_RESET;
        end else if (w_cfg_wr) begin
            r_buffer_limit <= pwdata[lpfrb_pkg::LIMIT_W-1:0];
        end
    end

    assign busy = w_qstat.full;

    lpfrb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (start),
        .i_cmd   (i_cmd),
        .i_first (i_first_of_frame),
        .i_len   (i_frame_length),
        .i_data  (i_data_byte),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    lpfrb_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_buffer_limit),
        .i_head     (w_head),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_data_out (o_data_out),
        .o_len_out  (o_frame_length_out),
        .o_first    (o_frame_first),
        .o_last     (o_frame_last)
    );

    `ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, start && !busy, w_qstat.valid, "accepted command not queued")
    `ASSERT_IMPLIES(a_fail_fields_zero, i_clk, i_rst_n, o_done && (o_status != lpfrb_pkg::STATUS_OK), (o_data_out == 8'd0) && (o_frame_length_out == 8'd0) && !o_frame_first && !o_frame_last, "failed transfer carries payload")
    `ASSERT_IMPLIES(a_empty_frame_marks, i_clk, i_rst_n, o_done && o_frame_first && (o_frame_length_out == 8'd0), o_frame_last, "zero-length frame not marked last")

endmodule

`default_nettype wire
